### sv/ordered_collection_image_parser_unit_assert.svh
// Assertion macros used by the image parser checker.
// Clock i_clk and synchronous active-low reset i_rst_n are taken from the scope of use.
`ifndef ORDERED_COLLECTION_IMAGE_PARSER_UNIT_ASSERT_SVH
`define ORDERED_COLLECTION_IMAGE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define OCIP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OCIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ocip_pkg.sv
// Types and constants of the collection image parser.
// No dependencies; used by ocip_step, the top level and the checker.
package ocip_pkg;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ENTRY_HEAD,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    localparam logic [2:0] EV_CONSUMED = 3'd0;
    localparam logic [2:0] EV_HEADER   = 3'd1;
    localparam logic [2:0] EV_PAYLOAD  = 3'd2;
    localparam logic [2:0] EV_SUCCESS  = 3'd3;
    localparam logic [2:0] EV_ERROR    = 3'd4;

    localparam logic [2:0] ERR_COUNT_SIZE      = 3'd0;
    localparam logic [2:0] ERR_FRAMING         = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED       = 3'd2;
    localparam logic [2:0] ERR_INVALID_ENTRY   = 3'd3;
    localparam logic [2:0] ERR_TRAILING        = 3'd4;
    localparam logic [2:0] ERR_LENGTH_MISMATCH = 3'd5;

    localparam logic [1:0] CFG_SORTED_MODE     = 2'd0;
    localparam logic [1:0] CFG_ENTRY_COUNT     = 2'd1;
    localparam logic [1:0] CFG_TOTAL_LENGTH    = 2'd2;
    localparam logic [1:0] CFG_MAX_ENTRY_BYTES = 2'd3;

    localparam logic [31:0] MAX_ENTRY_RESET = 32'h2000_0000;
    localparam logic [31:0] IMAGE_HDR_BYTES = 32'd8;
    localparam logic [3:0]  FRAME_SORTED    = 4'd12;
    localparam logic [3:0]  FRAME_LIST      = 4'd4;
    localparam logic [3:0]  SCORE_END       = 4'd12;
    localparam logic [3:0]  LEN_END         = 4'd4;

    typedef struct packed {
        logic        sorted_mode;
        logic [31:0] entry_count;
        logic [31:0] total_length;
        logic [31:0] max_entry_bytes;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] field_shift;
        logic [3:0]  field_bytes_left;
        logic [31:0] payload_left;
        logic [31:0] entries_seen;
        logic [63:0] held_score;
        logic        error_flag;
        logic [2:0]  held_error;
    } t_state;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] entry_index;
        logic [63:0] score_bits;
        logic [31:0] entry_length;
        logic [7:0]  payload_byte;
        logic        entry_done;
        logic [2:0]  error_code;
    } t_result;

    localparam t_state STATE_CLEAR = '{
        phase: PH_HEADER, field_shift: 32'd0, field_bytes_left: 4'd0,
        payload_left: 32'd0, entries_seen: 32'd0, held_score: 64'd0,
        error_flag: 1'b0, held_error: 3'd0};

    // "LZS1" for sorted sets, "LVL1" for lists
    function automatic logic [7:0] magic_byte(input logic sorted, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h4C;
            2'd1:    b = sorted ? 8'h5A : 8'h56;
            2'd2:    b = sorted ? 8'h53 : 8'h4C;
            default: b = 8'h31;
        endcase
        return b;
    endfunction

endpackage

### sv/ordered_collection_image_parser_unit.sv
// Collection image parser: one byte request per cycle, one result per request.
// A request is taken into the input register and moves on into the result register
// once that register is free. Throughput 1 request per cycle while the result is not stalled.
// Input stalls only while a stalled result holds the result register.
// Synchronous active-low reset clears parse state, handshake valids and restores
// register defaults (max_entry_bytes 2^29, others 0). End request rearms the parser.
module ordered_collection_image_parser_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_entry_index,
    output logic [63:0] o_score_bits,
    output logic [31:0] o_entry_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_entry_done,
    output logic [2:0]  o_error_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    ocip_pkg::t_cfg         r_cfg;
    ocip_pkg::t_state       r_state, n_state;
    logic [LENGTH_BITS-1:0] r_byte_pos, n_byte_pos;
    ocip_pkg::t_result      r_result, n_result;
    logic                   r_in_valid, r_in_func, r_out_valid;
    logic [7:0]             r_in_byte;
    logic                   out_free, fire;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    ocip_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .i_func     (r_in_func),
        .i_data_byte(r_in_byte),
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_byte_pos (r_byte_pos),
        .o_state    (n_state),
        .o_byte_pos (n_byte_pos),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sorted_mode     <= 1'b0;
            r_cfg.entry_count     <= 32'd0;
            r_cfg.total_length    <= 32'd0;
            r_cfg.max_entry_bytes <= ocip_pkg::MAX_ENTRY_RESET;
            r_state               <= ocip_pkg::STATE_CLEAR;
            r_byte_pos            <= '0;
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ocip_pkg::CFG_SORTED_MODE:     r_cfg.sorted_mode     <= i_cfg_data[0];
                    ocip_pkg::CFG_ENTRY_COUNT:     r_cfg.entry_count     <= i_cfg_data;
                    ocip_pkg::CFG_TOTAL_LENGTH:    r_cfg.total_length    <= i_cfg_data;
                    ocip_pkg::CFG_MAX_ENTRY_BYTES: r_cfg.max_entry_bytes <= i_cfg_data;
                    default: ;
                endcase
            end
            // input stage advances whenever it is not held by a full result stage
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_state    <= n_state;
                r_byte_pos <= n_byte_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_func <= i_func;
            r_in_byte <= i_data_byte;
        end
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_result.event_res;
    assign o_entry_index  = r_result.entry_index;
    assign o_score_bits   = r_result.score_bits;
    assign o_entry_length = r_result.entry_length;
    assign o_payload_byte = r_result.payload_byte;
    assign o_entry_done   = r_result.entry_done;
    assign o_error_code   = r_result.error_code;

endmodule

### sv/ocip_step.sv
// One-byte step of the image parser: next state and result of one request.
// Pure combinational; depends on ocip_pkg.
module ocip_step #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                   i_func,
    input  logic [7:0]             i_data_byte,
    input  ocip_pkg::t_cfg         i_cfg,
    input  ocip_pkg::t_state       i_state,
    input  logic [LENGTH_BITS-1:0] i_byte_pos,
    output ocip_pkg::t_state       o_state,
    output logic [LENGTH_BITS-1:0] o_byte_pos,
    output ocip_pkg::t_result      o_result
);
    localparam int CW = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;
    localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

    logic [CW-1:0]          pos_w, tot_w, after_w, len_w, pos_inc_w;
    logic [LENGTH_BITS-1:0] pos_inc;
    logic [3:0]             frame;
    logic [35:0]            count_f;
    logic [31:0]            tot_m8;
    logic                   count_bad, magic_ok;
    logic [31:0]            hdr_shift;
    logic [3:0]             fbl_eff, fbl_dec, sidx_w, fidx_w;
    logic [63:0]            score_base, score_new;
    logic [31:0]            fs_base, fs_new;
    logic                   trunc_bad, nan, len_bad;
    logic [31:0]            es_inc, pl_dec;
    logic                   fin_done, trail, pl_done;

    assign pos_w     = CW'(i_byte_pos);
    assign tot_w     = CW'(i_cfg.total_length);
    assign pos_inc   = (i_byte_pos != POS_MAX) ? i_byte_pos + 1'b1 : i_byte_pos;
    assign pos_inc_w = CW'(pos_inc);
    assign after_w   = pos_w + CW'(1);
    assign frame     = i_cfg.sorted_mode ? ocip_pkg::FRAME_SORTED : ocip_pkg::FRAME_LIST;

    // count > (total-8)/frame  <=>  count*frame > total-8
    assign count_f   = i_cfg.sorted_mode
                     ? ({i_cfg.entry_count, 4'b0000} - {2'b00, i_cfg.entry_count, 2'b00})
                     : {2'b00, i_cfg.entry_count, 2'b00};
    assign tot_m8    = i_cfg.total_length - ocip_pkg::IMAGE_HDR_BYTES;
    assign count_bad = count_f > {4'd0, tot_m8};
    assign magic_ok  = i_data_byte == ocip_pkg::magic_byte(i_cfg.sorted_mode, i_byte_pos[1:0]);
    assign hdr_shift = ((i_byte_pos == '0) ? 32'd0 : i_state.field_shift)
                     | (32'(i_data_byte) << {i_byte_pos[1:0], 3'b000});

    // Entry header: a fresh field starts when no bytes are left
    assign fbl_eff    = (i_state.field_bytes_left == 4'd0) ? frame : i_state.field_bytes_left;
    assign score_base = (i_state.field_bytes_left == 4'd0) ? 64'd0 : i_state.held_score;
    assign fs_base    = (i_state.field_bytes_left == 4'd0) ? 32'd0 : i_state.field_shift;
    assign sidx_w     = ocip_pkg::SCORE_END - fbl_eff;
    assign fidx_w     = ocip_pkg::LEN_END - fbl_eff;
    assign score_new  = (fbl_eff > 4'd4)
                      ? (score_base | (64'(i_data_byte) << {sidx_w[2:0], 3'b000}))
                      : score_base;
    assign fs_new     = (fbl_eff > 4'd4)
                      ? fs_base
                      : (fs_base | (32'(i_data_byte) << {fidx_w[1:0], 3'b000}));
    assign fbl_dec    = fbl_eff - 4'd1;
    assign trunc_bad  = (pos_w > tot_w) || ((tot_w - pos_w) < CW'(frame));
    assign len_w      = CW'(fs_new);
    assign nan        = (&score_new[62:52]) && (|score_new[51:0]);
    assign len_bad    = nan || (fs_new > i_cfg.max_entry_bytes) || (after_w > tot_w)
                      || (len_w > (tot_w - after_w));

    assign es_inc   = i_state.entries_seen + 32'd1;
    assign fin_done = es_inc >= i_cfg.entry_count;
    assign trail    = pos_inc_w != tot_w;
    assign pl_dec   = (i_state.payload_left != 32'd0) ? i_state.payload_left - 32'd1 : 32'd0;
    assign pl_done  = pl_dec == 32'd0;

    always_comb begin
        o_state    = i_state;
        o_byte_pos = i_byte_pos;
        o_result   = '0;
        o_result.entry_index = i_state.entries_seen;

        if (i_func) begin
            o_result.event_res = ocip_pkg::EV_ERROR;
            if (i_state.error_flag) begin
                o_result.error_code = i_state.held_error;
            end else if (i_state.phase == ocip_pkg::PH_DONE && pos_w == tot_w) begin
                o_result.event_res = ocip_pkg::EV_SUCCESS;
            end else begin
                o_result.error_code = ocip_pkg::ERR_LENGTH_MISMATCH;
            end
            // rearm for the next image
            o_state    = ocip_pkg::STATE_CLEAR;
            o_byte_pos = '0;
        end else if (i_state.error_flag) begin
            o_result.event_res  = ocip_pkg::EV_ERROR;
            o_result.error_code = i_state.held_error;
        end else begin
            o_byte_pos = pos_inc;
            case (i_state.phase)
                ocip_pkg::PH_HEADER: begin
                    if (i_byte_pos == '0 && (i_cfg.entry_count == 32'd0 ||
                        i_cfg.total_length < ocip_pkg::IMAGE_HDR_BYTES)) begin
                        o_state.error_flag = 1'b1;
                        o_state.held_error = ocip_pkg::ERR_COUNT_SIZE;
                    end else if ((i_byte_pos == '0 && count_bad) ||
                                 (pos_w < CW'(4) && !magic_ok) ||
                                 (pos_w >= CW'(7) && hdr_shift != i_cfg.entry_count)) begin
                        o_state.error_flag = 1'b1;
                        o_state.held_error = ocip_pkg::ERR_FRAMING;
                    end else if (pos_w >= CW'(7)) begin
                        o_state.phase            = ocip_pkg::PH_ENTRY_HEAD;
                        o_state.field_bytes_left = 4'd0;
                        o_state.entries_seen     = 32'd0;
                        o_state.field_shift      = 32'd0;
                    end else if (pos_w >= CW'(4)) begin
                        o_state.field_shift = hdr_shift;
                    end else begin
                        o_state.field_shift = 32'd0;
                    end
                end
                ocip_pkg::PH_ENTRY_HEAD: begin
                    if (i_state.field_bytes_left == 4'd0 && trunc_bad) begin
                        o_state.error_flag = 1'b1;
                        o_state.held_error = ocip_pkg::ERR_TRUNCATED;
                    end else if (fbl_dec == 4'd0 && len_bad) begin
                        o_state.error_flag = 1'b1;
                        o_state.held_error = ocip_pkg::ERR_INVALID_ENTRY;
                    end else begin
                        o_state.held_score       = score_new;
                        o_state.field_shift      = fs_new;
                        o_state.field_bytes_left = fbl_dec;
                        if (fbl_dec == 4'd0) begin
                            o_result.event_res    = ocip_pkg::EV_HEADER;
                            o_result.score_bits   = score_new;
                            o_result.entry_length = fs_new;
                            o_result.entry_done   = fs_new == 32'd0;
                            if (fs_new == 32'd0) begin
                                o_state.entries_seen = es_inc;
                                if (fin_done) begin
                                    o_state.phase = ocip_pkg::PH_DONE;
                                    if (trail) begin
                                        o_state.error_flag = 1'b1;
                                        o_state.held_error = ocip_pkg::ERR_TRAILING;
                                    end
                                end else begin
                                    o_state.phase = ocip_pkg::PH_ENTRY_HEAD;
                                end
                            end else begin
                                o_state.payload_left = fs_new;
                                o_state.phase        = ocip_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                ocip_pkg::PH_PAYLOAD: begin
                    o_state.payload_left  = pl_dec;
                    o_result.event_res    = ocip_pkg::EV_PAYLOAD;
                    o_result.payload_byte = i_data_byte;
                    o_result.entry_done   = pl_done;
                    if (pl_done) begin
                        o_state.entries_seen = es_inc;
                        if (fin_done) begin
                            o_state.phase = ocip_pkg::PH_DONE;
                            if (trail) begin
                                o_state.error_flag = 1'b1;
                                o_state.held_error = ocip_pkg::ERR_TRAILING;
                            end
                        end else begin
                            o_state.phase            = ocip_pkg::PH_ENTRY_HEAD;
                            o_state.field_bytes_left = 4'd0;
                        end
                    end
                end
                default: begin
                    // byte after a complete image
                    o_state.error_flag = 1'b1;
                    o_state.held_error = ocip_pkg::ERR_LENGTH_MISMATCH;
                end
            endcase
            // trailing error is held for later requests; this one reports normally
            if (o_state.error_flag && o_state.held_error != ocip_pkg::ERR_TRAILING) begin
                o_result              = '0;
                o_result.entry_index  = i_state.entries_seen;
                o_result.event_res    = ocip_pkg::EV_ERROR;
                o_result.error_code   = o_state.held_error;
            end
        end
    end

endmodule

### sv/ocip_checker.sv
// Port-level checker for the collection image parser, bound to the top level.
// Depends on ocip_pkg and ordered_collection_image_parser_unit_assert.svh.
`include "ordered_collection_image_parser_unit_assert.svh"

module ocip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_event_res,
    input logic [31:0] o_entry_index,
    input logic [63:0] o_score_bits,
    input logic [31:0] o_entry_length,
    input logic [7:0]  o_payload_byte,
    input logic        o_entry_done,
    input logic [2:0]  o_error_code
);

    `OCIP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_event_res) && $stable(o_entry_index) && $stable(o_payload_byte), "stalled result changed")

    `OCIP_ASSERT_SAME(a_code_only_on_error, o_out_valid && o_event_res != ocip_pkg::EV_ERROR, o_error_code == 3'd0, "error code on non-error event")

    `OCIP_ASSERT_SAME(a_done_on_entry_event, o_out_valid && o_entry_done, o_event_res == ocip_pkg::EV_HEADER || o_event_res == ocip_pkg::EV_PAYLOAD, "entry done on wrong event")

    `OCIP_ASSERT_SAME(a_payload_fields, o_out_valid && o_event_res == ocip_pkg::EV_PAYLOAD, o_entry_length == 32'd0 && o_score_bits == 64'd0, "payload event carries header fields")

endmodule

bind ordered_collection_image_parser_unit ocip_checker u_ocip_checker (.*);
